[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg
// Shared constants, codes and types of the sprite stamp compositor.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int DEF_MAX_ROWS   = 512;
    localparam int DEF_MAX_COLS   = 512;
    localparam int DEF_MAX_SPRITE = 32;

    localparam int POS_W      = 19;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 9;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 10;
    localparam int SDIM_W     = 6;
    localparam int NOISE_W    = 19;
    localparam int ACT_W      = 2;
    localparam int SEL_W      = 2;
    localparam int TDATA_W    = 40;
    localparam int TUSER_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DOT   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

    localparam logic [SEL_W-1:0] SEL_WHITE = 2'd0;
    localparam logic [SEL_W-1:0] SEL_BLACK = 2'd1;
    localparam logic [SEL_W-1:0] SEL_ALPHA = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EYE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_ROWS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_COLS = 3'd6;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_CLEAR  = 3'd0;
    localparam kind_t KIND_LOAD_W = 3'd1;
    localparam kind_t KIND_LOAD_B = 3'd2;
    localparam kind_t KIND_LOAD_A = 3'd3;
    localparam kind_t KIND_DOT    = 3'd4;
    localparam kind_t KIND_READ   = 3'd5;

    localparam logic [VAL_W-1:0] COLOUR_MAX = 9'd255;
    localparam logic [VAL_W-1:0] ALPHA_ONE  = 9'd256;
    localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   position;
        logic               dot_parity;
        logic               noise_flag;
        logic [IDX_W-1:0]   sprite_index;
        logic [VAL_W-1:0]   sprite_value;
    } item_t;

    // Sizes already clamped to 1..max.
    typedef struct packed {
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [PIX_W-1:0]   background;
        logic [NOISE_W-1:0] noise_limit;
        logic               left_eye;
        logic [SDIM_W-1:0]  srows;
        logic [SDIM_W-1:0]  scols;
    } cfg_t;

endpackage

[src/asc_div.sv]
// ----------------------------------------------------------------------------
// asc_div
// Restoring divider, one quotient bit per cycle, for the dot centre.
// ----------------------------------------------------------------------------
module asc_div
    import asc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic             done,
    output logic [POS_W-1:0] quotient,
    output logic [DIM_W-1:0] remainder
);

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] dvd_reg;
    logic [DIM_W-1:0] rem_reg;

    logic [DIM_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, dvd_reg[POS_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(POS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // quotient bits shift in as dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[POS_W-2:0], fits};
            rem_reg <= fits ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

[src/asc_front.sv]
// ----------------------------------------------------------------------------
// asc_front
// Input side: decodes each item, drops bad loads, queues the rest.
// ----------------------------------------------------------------------------
module asc_front
    import asc_pkg::*;
#(
    parameter int MAX_SPRITE = DEF_MAX_SPRITE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // position[18:0], dot_parity[19], noise_flag[20], sprite_index[30:21],
    // sprite_value[39:31]
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // action[1:0], sprite_select[3:2]
    input  logic [TUSER_W-1:0] s_axis_tuser,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_ready
);

    localparam int SPRITE_DEPTH = MAX_SPRITE * MAX_SPRITE;

    logic [ACT_W-1:0] action;
    logic [SEL_W-1:0] sel;
    logic [VAL_W-1:0] val;
    logic             idx_ok;
    logic             keep;
    item_t            item;

    item_t            fifo_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign action = s_axis_tuser[1:0];
    assign sel    = s_axis_tuser[3:2];
    assign val    = s_axis_tdata[39:31];
    assign idx_ok = 32'(s_axis_tdata[30:21]) < SPRITE_DEPTH;

    always_comb
    begin
        item.position     = s_axis_tdata[18:0];
        item.dot_parity   = s_axis_tdata[19];
        item.noise_flag   = s_axis_tdata[20];
        item.sprite_index = s_axis_tdata[30:21];
        item.sprite_value = (val > COLOUR_MAX) ? COLOUR_MAX : val;
        item.kind         = KIND_CLEAR;
        keep              = 1'b1;
        unique case (action)
            ACT_CLEAR: item.kind = KIND_CLEAR;
            ACT_DOT:   item.kind = KIND_DOT;
            ACT_READ:  item.kind = KIND_READ;
            ACT_LOAD:
            begin
                keep = idx_ok;
                unique case (sel)
                    SEL_WHITE: item.kind = KIND_LOAD_W;
                    SEL_BLACK: item.kind = KIND_LOAD_B;
                    SEL_ALPHA:
                    begin
                        item.kind         = KIND_LOAD_A;
                        item.sprite_value = (val > ALPHA_ONE) ? ALPHA_ONE : val;
                    end
                    default:   keep = 1'b0;
                endcase
            end
            default:   keep = 1'b0;
        endcase
    end

    assign s_axis_tready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = count_reg != '0;
    assign pop           = q_valid && q_ready;
    assign q_item        = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= item;
    end

endmodule

[src/asc_back.sv]
// ----------------------------------------------------------------------------
// asc_back
// Execution side: frame and sprite memories, clear sweep, dot blending
// pipeline and pixel readout.
// ----------------------------------------------------------------------------
module asc_back
    import asc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_SPRITE = DEF_MAX_SPRITE
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  item_t            q_item,
    output logic             q_ready,
    input  cfg_t             cfg,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // pixel_value[7:0]
    output logic [PIX_W-1:0] m_axis_tdata
);

    localparam int FRAME_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int FA_W         = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int SPRITE_DEPTH = MAX_SPRITE * MAX_SPRITE;
    localparam int SA_W         = (SPRITE_DEPTH > 1) ? $clog2(SPRITE_DEPTH) : 1;
    localparam int AREA_W       = 2 * DIM_W;
    localparam int RW           = DIM_W + 2;
    localparam int CW           = POS_W + 3;
    localparam int FW           = CW + DIM_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SETUP = 3'd3;
    localparam logic [2:0] S_BASE  = 3'd4;
    localparam logic [2:0] S_BLEND = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_READ  = 3'd7;

    logic [2:0]         state_reg;
    logic [FA_W-1:0]    clr_addr_reg;
    logic [NOISE_W-1:0] noise_seen_reg;
    logic               white_reg;
    logic [AREA_W-1:0]  area_reg;
    logic               rd_ok_reg;
    logic               m_valid_reg;
    logic [PIX_W-1:0]   m_data_reg;

    logic signed [RW-1:0] r0_reg;
    logic signed [CW-1:0] c0_reg;
    logic signed [RW-1:0] r_reg;
    logic signed [CW-1:0] c_reg;
    logic signed [FW-1:0] fa_col_reg;
    logic [SDIM_W-1:0]    i_reg;
    logic [SDIM_W-1:0]    j_reg;
    logic [SA_W-1:0]      sa_reg;
    logic [SA_W-1:0]      sa_col_reg;
    logic                 p1_valid_reg;
    logic [FA_W-1:0]      p1_fa_reg;

    logic [PIX_W-1:0] frame_mem [FRAME_DEPTH];
    logic [PIX_W-1:0] white_mem [SPRITE_DEPTH];
    logic [PIX_W-1:0] black_mem [SPRITE_DEPTH];
    logic [VAL_W-1:0] alpha_mem [SPRITE_DEPTH];
    logic [PIX_W-1:0] frame_q;
    logic [PIX_W-1:0] white_q;
    logic [PIX_W-1:0] black_q;
    logic [VAL_W-1:0] alpha_q;

    logic             pop;
    logic             div_start;
    logic             div_done;
    logic [POS_W-1:0] div_quo;
    logic [DIM_W-1:0] div_rem;

    logic [SDIM_W-2:0]    hr;
    logic [SDIM_W-2:0]    hc;
    logic [SDIM_W-1:0]    span_r;
    logic [SDIM_W-1:0]    span_c;
    logic                 under;
    logic                 pick_white;
    logic [DIM_W-1:0]     crow;
    logic [CW-1:0]        ccol;
    logic                 in_range;
    logic signed [FW-1:0] fa_full;
    logic [FA_W-1:0]      frd_addr;
    logic                 fwe;
    logic [FA_W-1:0]      fwr_addr;
    logic [PIX_W-1:0]     fwr_data;
    logic [PIX_W-1:0]     colour;
    logic [PIX_W+VAL_W-1:0] blend_sum;

    assign hr     = cfg.srows[SDIM_W-1:1];
    assign hc     = cfg.scols[SDIM_W-1:1];
    assign span_r = {hr, 1'b0};
    assign span_c = {hc, 1'b0};

    assign q_ready = (state_reg == S_IDLE)
                     && ((q_item.kind != KIND_READ) || !m_valid_reg);
    assign pop       = q_valid && q_ready;
    assign div_start = pop && (q_item.kind == KIND_DOT);

    asc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_item.position),
        .divisor   (cfg.rows),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // sprite choice for a dot
    assign under      = noise_seen_reg < cfg.noise_limit;
    assign pick_white = (q_item.noise_flag && under)
                        ? (q_item.dot_parity == cfg.left_eye)
                        : !q_item.dot_parity;

    // row = remainder (0 means last row), column = quotient rounded up
    assign crow = (div_rem == '0) ? cfg.rows : div_rem;
    assign ccol = CW'(div_quo) + CW'(div_rem != '0);

    assign in_range = (c_reg >= CW'(1)) && (c_reg <= $signed(CW'(cfg.cols)))
                      && (r_reg >= RW'(1)) && (r_reg <= $signed(RW'(cfg.rows)));
    assign fa_full  = fa_col_reg + FW'(r_reg) - FW'(1);

    assign frd_addr = (state_reg == S_IDLE) ? FA_W'(q_item.position - 1'b1)
                                            : FA_W'(fa_full);

    assign colour    = white_reg ? white_q : black_q;
    assign blend_sum = (PIX_W+VAL_W)'((ALPHA_ONE - alpha_q) * frame_q)
                     + (PIX_W+VAL_W)'(alpha_q * colour);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            fwe      = 1'b1;
            fwr_addr = clr_addr_reg;
            fwr_data = cfg.background;
        end
        else
        begin
            fwe      = p1_valid_reg;
            fwr_addr = p1_fa_reg;
            fwr_data = blend_sum[PIX_W+VAL_W-2:PIX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
            frame_mem[fwr_addr] <= fwr_data;
        frame_q <= frame_mem[frd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && (q_item.kind == KIND_LOAD_W))
            white_mem[SA_W'(q_item.sprite_index)] <= q_item.sprite_value[PIX_W-1:0];
        if (pop && (q_item.kind == KIND_LOAD_B))
            black_mem[SA_W'(q_item.sprite_index)] <= q_item.sprite_value[PIX_W-1:0];
        if (pop && (q_item.kind == KIND_LOAD_A))
            alpha_mem[SA_W'(q_item.sprite_index)] <= q_item.sprite_value;
        white_q <= white_mem[sa_reg];
        black_q <= black_mem[sa_reg];
        alpha_q <= alpha_mem[sa_reg];
    end

    always_ff @(posedge clk)
    begin
        area_reg  <= cfg.rows * cfg.cols;
        p1_fa_reg <= FA_W'(fa_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clr_addr_reg   <= '0;
            noise_seen_reg <= '0;
            white_reg      <= 1'b0;
            rd_ok_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            r0_reg         <= '0;
            c0_reg         <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            fa_col_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            sa_reg         <= '0;
            sa_col_reg     <= '0;
            p1_valid_reg   <= 1'b0;
        end
        else
        begin
            // reads issued in the blend state write back in the next cycle
            p1_valid_reg <= (state_reg == S_BLEND) && in_range;
            if (state_reg == S_READ)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (q_item.kind)
                            KIND_CLEAR:
                            begin
                                clr_addr_reg   <= '0;
                                noise_seen_reg <= '0;
                                state_reg      <= S_CLEAR;
                            end
                            KIND_DOT:
                            begin
                                white_reg <= pick_white;
                                if (q_item.noise_flag && (noise_seen_reg != NOISE_MAX))
                                    noise_seen_reg <= noise_seen_reg + 1'b1;
                                state_reg <= S_DIV;
                            end
                            KIND_READ:
                            begin
                                rd_ok_reg <= (q_item.position != '0)
                                             && (AREA_W'(q_item.position) <= area_reg);
                                state_reg <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    if (clr_addr_reg == FA_W'(FRAME_DEPTH - 1))
                        state_reg <= S_IDLE;
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    r0_reg    <= $signed(RW'(crow)) - $signed(RW'(hr)) + RW'(1);
                    c0_reg    <= $signed(ccol) - $signed(CW'(hc)) + CW'(1);
                    state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    fa_col_reg <= FW'(c0_reg - CW'(1)) * $signed(FW'(cfg.rows));
                    r_reg      <= r0_reg;
                    c_reg      <= c0_reg;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    sa_reg     <= '0;
                    sa_col_reg <= '0;
                    state_reg  <= ((hr == '0) || (hc == '0)) ? S_IDLE : S_BLEND;
                end
                S_BLEND:
                begin
                    if (i_reg == span_r - 1'b1)
                    begin
                        i_reg      <= '0;
                        r_reg      <= r0_reg;
                        j_reg      <= j_reg + 1'b1;
                        c_reg      <= c_reg + CW'(1);
                        fa_col_reg <= fa_col_reg + $signed(FW'(cfg.rows));
                        sa_col_reg <= sa_col_reg + SA_W'(cfg.srows);
                        sa_reg     <= sa_col_reg + SA_W'(cfg.srows);
                        if (j_reg == span_c - 1'b1)
                            state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        i_reg  <= i_reg + 1'b1;
                        r_reg  <= r_reg + RW'(1);
                        sa_reg <= sa_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_IDLE;
                end
                S_READ:
                begin
                    m_data_reg <= rd_ok_reg ? frame_q : '0;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[src/alpha_sprite_stamp_compositor.sv]
// ----------------------------------------------------------------------------
// alpha_sprite_stamp_compositor
// Frame compositor that alpha-blends white or black sprites into a
// column-major frame store.
// ----------------------------------------------------------------------------
// Items are handled one at a time behind a four-entry input queue. A sprite
// load is written as the item leaves the queue. For a dot, a serial divider
// finds the centre, then the window of (2*(sprite_rows/2)) by
// (2*(sprite_cols/2)) pixels goes through one frame read-modify-write per
// cycle. A clear writes every frame store word, MAX_ROWS * MAX_COLS words
// (262144 by default), through the single frame write port. Reads before the
// first clear return undefined pixels.
module alpha_sprite_stamp_compositor
    import asc_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_SPRITE = DEF_MAX_SPRITE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position[18:0], dot_parity[19], noise_flag[20], sprite_index[30:21],
    // sprite_value[39:31]
    input  logic [TDATA_W-1:0]    s_axis_tdata,
    // action[1:0], sprite_select[3:2]
    input  logic [TUSER_W-1:0]    s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_value[7:0]
    output logic [PIX_W-1:0]      m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [DIM_W-1:0]  ROWS_CAP = (MAX_ROWS > 1023) ? '1 : DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0]  COLS_CAP = (MAX_COLS > 1023) ? '1 : DIM_W'(MAX_COLS);
    localparam logic [SDIM_W-1:0] SPR_CAP  = (MAX_SPRITE > 63) ? '1 : SDIM_W'(MAX_SPRITE);

    logic [DIM_W-1:0]   image_rows_reg;
    logic [DIM_W-1:0]   image_cols_reg;
    logic [PIX_W-1:0]   background_reg;
    logic [NOISE_W-1:0] noise_limit_reg;
    logic               left_eye_reg;
    logic [SDIM_W-1:0]  sprite_rows_reg;
    logic [SDIM_W-1:0]  sprite_cols_reg;

    cfg_t  cfg;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg  <= 10'd512;
            image_cols_reg  <= 10'd512;
            background_reg  <= 8'd128;
            noise_limit_reg <= '0;
            left_eye_reg    <= 1'b1;
            sprite_rows_reg <= 6'd16;
            sprite_cols_reg <= 6'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS:  image_rows_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_COLS:  image_cols_reg  <= cfg_data[DIM_W-1:0];
                REG_BACKGROUND:  background_reg  <= cfg_data[PIX_W-1:0];
                REG_NOISE_LIMIT: noise_limit_reg <= cfg_data[NOISE_W-1:0];
                REG_LEFT_EYE:    left_eye_reg    <= cfg_data[0];
                REG_SPRITE_ROWS: sprite_rows_reg <= cfg_data[SDIM_W-1:0];
                REG_SPRITE_COLS: sprite_cols_reg <= cfg_data[SDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb
    begin
        cfg.rows        = (image_rows_reg == '0) ? DIM_W'(1)
                        : (image_rows_reg > ROWS_CAP) ? ROWS_CAP : image_rows_reg;
        cfg.cols        = (image_cols_reg == '0) ? DIM_W'(1)
                        : (image_cols_reg > COLS_CAP) ? COLS_CAP : image_cols_reg;
        cfg.srows       = (sprite_rows_reg == '0) ? SDIM_W'(1)
                        : (sprite_rows_reg > SPR_CAP) ? SPR_CAP : sprite_rows_reg;
        cfg.scols       = (sprite_cols_reg == '0) ? SDIM_W'(1)
                        : (sprite_cols_reg > SPR_CAP) ? SPR_CAP : sprite_cols_reg;
        cfg.background  = background_reg;
        cfg.noise_limit = noise_limit_reg;
        cfg.left_eye    = left_eye_reg;
    end

    asc_front #(
        .MAX_SPRITE (MAX_SPRITE)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready)
    );

    asc_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_SPRITE (MAX_SPRITE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready),
        .cfg           (cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[src/asc_checker.sv]
// ----------------------------------------------------------------------------
// asc_checker
// Port-level checks: results only answer read items, and hold while stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asc_checker
    import asc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [TUSER_W-1:0] s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [PIX_W-1:0]   m_axis_tdata
);

    logic       rd_acc;
    logic       out_acc;
    logic [3:0] pend_reg;

    assign rd_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == ACT_READ);
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // read items accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 4'(rd_acc) - 4'(out_acc);
    end

    `ASC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASC_ASSERT_IMPL(a_out_has_read, m_axis_tvalid, pend_reg != 4'd0)
    `ASC_ASSERT_NEXT(a_out_drained, out_acc && (pend_reg == 4'd1) && !rd_acc, !m_axis_tvalid)

endmodule

bind alpha_sprite_stamp_compositor asc_checker u_asc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
